>>> rtl/dsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared types and constants of the differential spectrum decoder.
// ----------------------------------------------------------------------------
package dsd_pkg;

    // Escape codes of the byte stream.
    localparam logic [7:0]  CODE_DIFF16 = 8'h7f;
    localparam logic [7:0]  CODE_ABS32  = 8'h80;

    // Register defaults and limits.
    localparam logic [11:0] THRESHOLD_RESET   = 12'd285;
    localparam int          MAX_BLOCK_CH_DEF  = 2048;

    // Configuration register indexes.
    localparam int          CFG_IDX_W         = 1;
    localparam int          CFG_DATA_W        = 12;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN = 1'b1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        block_start;
        logic [11:0] channels_in;
        logic [11:0] max_out;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] channel_value;
        logic [10:0]        channel_index;
        logic               last_channel;
    } t_out_item;

    typedef struct packed {
        logic [11:0] truncation_threshold;
        logic        payload_big_endian;
    } t_cfg;

endpackage

>>> rtl/dsd_count_load.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_count_load
// Works out the channel count loaded at the start of a block.
// ----------------------------------------------------------------------------
module dsd_count_load #(
    parameter int MAX_BLOCK_CHANNELS = dsd_pkg::MAX_BLOCK_CH_DEF
) (
    input  logic [11:0] i_channels_in,
    input  logic [11:0] i_max_out,
    input  logic [11:0] i_threshold,
    output logic [11:0] o_count
);
    import dsd_pkg::*;

    localparam int LIM_W = $clog2(MAX_BLOCK_CHANNELS + 1);
    localparam int CMP_W = (LIM_W > 12) ? LIM_W : 12;
    localparam logic [CMP_W-1:0] LIMIT = CMP_W'(MAX_BLOCK_CHANNELS);

    logic [11:0] trimmed;
    logic [11:0] fitted;

    always_comb begin
        // A count above the threshold drops its possibly truncated last channel.
        trimmed = (i_channels_in > i_threshold) ? i_channels_in - 12'd1 : i_channels_in;
        fitted  = (trimmed > i_max_out) ? i_max_out : trimmed;
        if (CMP_W'(fitted) > LIMIT) begin
            o_count = LIMIT[11:0];
        end else begin
            o_count = fitted;
        end
    end

endmodule

>>> rtl/dsd_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_decoder
// Decoder state and the per-byte update; gives the result of one byte.
// ----------------------------------------------------------------------------
module dsd_decoder #(
    parameter int MAX_BLOCK_CHANNELS = dsd_pkg::MAX_BLOCK_CH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  dsd_pkg::t_in_item  i_item,
    input  dsd_pkg::t_cfg      i_cfg,
    output logic               o_res_valid,
    output dsd_pkg::t_out_item o_res
);
    import dsd_pkg::*;

    logic [31:0] r_value,    n_value;
    logic [2:0]  r_left,     n_left;
    logic        r_abs,      n_abs;
    logic [31:0] r_buf,      n_buf;
    logic [11:0] r_remain,   n_remain;
    logic [10:0] r_pos,      n_pos;

    logic [11:0] load_count;
    logic [1:0]  slot;
    logic        emit;

    dsd_count_load #(
        .MAX_BLOCK_CHANNELS (MAX_BLOCK_CHANNELS)
    ) u_count_load (
        .i_channels_in (i_item.channels_in),
        .i_max_out     (i_item.max_out),
        .i_threshold   (i_cfg.truncation_threshold),
        .o_count       (load_count)
    );

    always_comb begin
        n_value  = r_value;
        n_left   = r_left;
        n_abs    = r_abs;
        n_buf    = r_buf;
        n_remain = r_remain;
        n_pos    = r_pos;
        emit     = 1'b0;
        slot     = 2'd0;

        if (i_item.block_start) begin
            n_value  = 32'd0;
            n_left   = 3'd0;
            n_abs    = 1'b0;
            n_buf    = 32'd0;
            n_pos    = 11'd0;
            n_remain = load_count;
        end

        if (n_remain != 12'd0) begin
            if (n_left != 3'd0) begin
                if (i_cfg.payload_big_endian) begin
                    n_buf = {n_buf[23:0], i_item.data_byte};
                end else begin
                    slot = (n_abs ? 2'd0 : 2'd2) - n_left[1:0];
                    case (slot)
                        2'd0:    n_buf[7:0]   = n_buf[7:0]   | i_item.data_byte;
                        2'd1:    n_buf[15:8]  = n_buf[15:8]  | i_item.data_byte;
                        2'd2:    n_buf[23:16] = n_buf[23:16] | i_item.data_byte;
                        default: n_buf[31:24] = n_buf[31:24] | i_item.data_byte;
                    endcase
                end
                n_left = n_left - 3'd1;
                if (n_left == 3'd0) begin
                    emit = 1'b1;
                    if (n_abs) begin
                        n_value = n_buf;
                    end else begin
                        n_value = n_value + {{16{n_buf[15]}}, n_buf[15:0]};
                    end
                end
            end else if (i_item.data_byte == CODE_DIFF16) begin
                n_left = 3'd2;
                n_abs  = 1'b0;
                n_buf  = 32'd0;
            end else if (i_item.data_byte == CODE_ABS32) begin
                n_left = 3'd4;
                n_abs  = 1'b1;
                n_buf  = 32'd0;
            end else begin
                emit    = 1'b1;
                n_value = n_value + {{24{i_item.data_byte[7]}}, i_item.data_byte};
            end
        end

        o_res_valid         = emit;
        o_res.channel_value = n_value;
        o_res.channel_index = n_pos;
        o_res.last_channel  = (n_remain == 12'd1);
        if (emit) begin
            n_remain = n_remain - 12'd1;
            n_pos    = n_pos + 11'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value  <= 32'd0;
            r_left   <= 3'd0;
            r_abs    <= 1'b0;
            r_buf    <= 32'd0;
            r_remain <= 12'd0;
            r_pos    <= 11'd0;
        end else if (i_step) begin
            r_value  <= n_value;
            r_left   <= n_left;
            r_abs    <= n_abs;
            r_buf    <= n_buf;
            r_remain <= n_remain;
            r_pos    <= n_pos;
        end
    end

endmodule

>>> rtl/differential_spectrum_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_spectrum_decoder_core
// Decodes a byte stream of differentially coded spectrum channels into one
// absolute channel value per channel.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Carries
//   input     in         i_in_valid / o_in_ready   t_in_item, one byte a beat
//   output    out        o_out_valid / i_out_ready t_out_item, one channel
//   config    in         i_cfg_we (no wait)        register index and data
//
// One byte is accepted in every cycle while the output side keeps up. A byte
// waits in the input register and its result, if any, is then registered in
// the output register. The rate is set by the single decode step between
// the two registers: one 32-bit add and the payload byte lanes. Synchronous
// active-low reset clears the channel count, so bytes before the first block
// start give no result. A stalled output holds both registers; o_in_ready
// then falls once the input register is also occupied.
// ----------------------------------------------------------------------------
module differential_spectrum_decoder_core #(
    parameter int MAX_BLOCK_CHANNELS = dsd_pkg::MAX_BLOCK_CH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input beats.
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  dsd_pkg::t_in_item              i_in_data,
    // Output beats.
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dsd_pkg::t_out_item             o_out_data,
    // Configuration writes.
    input  logic                           i_cfg_we,
    input  logic [dsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dsd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dsd_pkg::*;

    t_cfg       r_cfg;
    t_in_item   r_in;
    logic       r_in_valid;
    t_out_item  r_out;
    logic       r_out_valid;

    logic       advance;
    logic       res_valid;
    t_out_item  res;

    // The input register moves on when the output register is free or is
    // being emptied in this cycle; a new beat can then land behind it.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Config regs; the user writes only while the block is idle, unchecked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.truncation_threshold <= THRESHOLD_RESET;
            r_cfg.payload_big_endian   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_THRESHOLD:  r_cfg.truncation_threshold <= i_cfg_data[11:0];
                REG_BIG_ENDIAN: r_cfg.payload_big_endian   <= i_cfg_data[0];
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    dsd_decoder #(
        .MAX_BLOCK_CHANNELS (MAX_BLOCK_CHANNELS)
    ) u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_item      (r_in),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register. A byte that completes no channel leaves it empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

endmodule

>>> bench/dsd_channel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_channel_checker
// Watches the byte and channel beats of the differential spectrum decoder,
// decodes every accepted byte on its own and compares each channel beat with
// the oldest channel it still expects.
// ----------------------------------------------------------------------------
module dsd_channel_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  dsd_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  dsd_pkg::t_out_item             i_out_data,
    input  logic                           i_cfg_we,
    input  logic [dsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import dsd_pkg::*;

    localparam int          REPORT_LIMIT = 10;
    localparam logic [11:0] BLOCK_LIMIT  = 12'(MAX_BLOCK_CH_DEF);

    // Register copies.
    logic [11:0] threshold;
    logic        big_endian;

    // Decoder state.
    logic [31:0] running;
    logic [2:0]  bytes_left;
    logic        is_absolute;
    logic [31:0] payload;
    logic [11:0] remaining;
    logic [10:0] position;

    t_out_item   expected_channels[$];
    t_out_item   want_chan;

    task automatic push_channel();
        t_out_item chan;
        chan.channel_value = running;
        chan.channel_index = position;
        chan.last_channel  = (remaining == 12'd1);
        expected_channels.push_back(chan);
        remaining = remaining - 12'd1;
        position  = position + 11'd1;
    endtask

    task automatic decode_byte(input t_in_item item);
        logic [11:0] count;
        logic [2:0]  total;
        logic [1:0]  slot;
        if (item.block_start) begin
            count = item.channels_in;
            if (count > threshold) count = count - 12'd1;
            if (count > item.max_out) count = item.max_out;
            if (count > BLOCK_LIMIT) count = BLOCK_LIMIT;
            running     = '0;
            bytes_left  = '0;
            is_absolute = 1'b0;
            payload     = '0;
            position    = '0;
            remaining   = count;
        end
        if (remaining != 12'd0) begin
            if (bytes_left != 3'd0) begin
                total = is_absolute ? 3'd4 : 3'd2;
                if (big_endian) begin
                    payload = {payload[23:0], item.data_byte};
                end else begin
                    slot    = 2'(total - bytes_left);
                    payload = payload | (32'(item.data_byte) << (8 * slot));
                end
                bytes_left = bytes_left - 3'd1;
                if (bytes_left == 3'd0) begin
                    if (is_absolute) running = payload;
                    else running = running + {{16{payload[15]}}, payload[15:0]};
                    push_channel();
                end
            end else if (item.data_byte == CODE_DIFF16) begin
                bytes_left  = 3'd2;
                is_absolute = 1'b0;
                payload     = '0;
            end else if (item.data_byte == CODE_ABS32) begin
                bytes_left  = 3'd4;
                is_absolute = 1'b1;
                payload     = '0;
            end else begin
                running = running + {{24{item.data_byte[7]}}, item.data_byte};
                push_channel();
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            threshold    = THRESHOLD_RESET;
            big_endian   = 1'b0;
            running      = '0;
            bytes_left   = '0;
            is_absolute  = 1'b0;
            payload      = '0;
            remaining    = '0;
            position     = '0;
            o_fail_count = 0;
            expected_channels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_THRESHOLD:  threshold  = i_cfg_data[11:0];
                    REG_BIG_ENDIAN: big_endian = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) decode_byte(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_channels.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected channel value %0d index %0d last %0b",
                                 $time, i_out_data.channel_value,
                                 i_out_data.channel_index, i_out_data.last_channel);
                end else begin
                    want_chan = expected_channels.pop_front();
                    if (want_chan.channel_value !== i_out_data.channel_value ||
                        want_chan.channel_index !== i_out_data.channel_index ||
                        want_chan.last_channel  !== i_out_data.last_channel) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT)
                            $display({"%0t: expected value %0d index %0d last %0b,",
                                      " got value %0d index %0d last %0b"}, $time,
                                     want_chan.channel_value, want_chan.channel_index,
                                     want_chan.last_channel, i_out_data.channel_value,
                                     i_out_data.channel_index, i_out_data.last_channel);
                    end
                end
            end
        end
        o_pending = expected_channels.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the differential spectrum decoder with a directed byte stream and
// then with random blocks of coded channels under changing register settings
// and handshake pressure; a checker beside the block predicts every channel.
// ----------------------------------------------------------------------------
module testbench;
    import dsd_pkg::*;

    localparam int RANDOM_SEGMENTS = 8;
    localparam int SEGMENT_BYTES   = 90;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_item   = '0;
    logic                  out_ready = 1'b1;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;
    int        fail_count;
    int        pending;

    // Pressure knobs; send_idle_pct and stall_pct are in percent of cycles.
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic send_burst    = 1'b0;
    int   ready_burst   = 0;
    int   bytes_sent    = 0;

    // The next stream byte opens a block with these counts when start_next is set.
    logic        start_next   = 1'b0;
    logic [11:0] blk_channels = '0;
    logic [11:0] blk_room     = '0;

    always #4 clk = ~clk;

    differential_spectrum_decoder_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    dsd_channel_checker channel_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver side. Now and then a stretch of cycles with ready held high is
    // inserted so that back-to-back channel beats also happen in the stalling
    // phases; otherwise ready drops in stall_pct percent of the cycles.
    always @(negedge clk) begin
        if (ready_burst > 0) begin
            ready_burst <= ready_burst - 1;
            out_ready   <= 1'b1;
        end else if ($urandom_range(31) == 0) begin
            ready_burst <= $urandom_range(30, 8);
            out_ready   <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offers one byte beat and returns once it has been taken. Idle cycles in
    // front of the beat keep valid low; without a gap valid simply stays high
    // and only the payload moves on to the next byte.
    task automatic send_byte(input logic [7:0] data_b, input logic start,
                             input logic [11:0] channels, input logic [11:0] room);
        t_in_item beat;
        beat.data_byte   = data_b;
        beat.block_start = start;
        beat.channels_in = channels;
        beat.max_out     = room;
        if (!send_burst) begin
            while ($urandom_range(99) < send_idle_pct) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    // Sends a stream byte. The count fields of bytes that do not open a block
    // are ignored by the block, so they carry random values.
    task automatic put_byte(input logic [7:0] data_b);
        if (start_next) begin
            start_next = 1'b0;
            send_byte(data_b, 1'b1, blk_channels, blk_room);
        end else begin
            send_byte(data_b, 1'b0, 12'($urandom_range(2048)), 12'($urandom_range(2048)));
        end
    endtask

    // One channel code: a plain 8-bit difference, or an escape code with its
    // 16-bit difference or 32-bit absolute value. A cut code stops short of
    // its payload, so the next block start has to abandon it.
    task automatic send_code(input logic cut);
        logic [7:0] diff;
        int         kind;
        int         len;
        int         n;
        kind = cut ? $urandom_range(3, 2) : $urandom_range(3);
        if (kind < 2) begin
            diff = 8'($urandom);
            if (diff == CODE_DIFF16 || diff == CODE_ABS32) diff = diff ^ 8'h01;
            put_byte(diff);
        end else begin
            len = (kind == 2) ? 2 : 4;
            put_byte((kind == 2) ? CODE_DIFF16 : CODE_ABS32);
            n = cut ? $urandom_range(len - 1) : len;
            for (int i = 0; i < n; i++) put_byte(8'($urandom));
        end
    endtask

    // A block of channel codes. Most blocks are small and carry about as many
    // codes as channels, sometimes a few more that the block must ignore.
    // Rare blocks use large counts but are cut short by the next block start.
    task automatic send_random_block();
        int   codes;
        logic broken;
        if ($urandom_range(9) == 0) begin
            // Stray bytes between blocks.
            repeat ($urandom_range(3, 1)) put_byte(8'($urandom));
        end
        if ($urandom_range(15) == 0) begin
            blk_channels = 12'($urandom_range(2048));
            blk_room     = 12'($urandom_range(2048));
            codes        = $urandom_range(6, 1);
        end else begin
            blk_channels = 12'($urandom_range(12));
            blk_room     = 12'($urandom_range(14));
            codes        = int'(blk_channels) + $urandom_range(2);
            if (codes == 0) codes = 1;
        end
        broken     = ($urandom_range(7) == 0);
        send_burst = ($urandom_range(3) == 0);
        start_next = 1'b1;
        for (int i = 0; i < codes; i++) send_code(broken && (i == codes - 1));
    endtask

    // Lowers valid and waits until every expected channel has been delivered,
    // then lets the input and output registers empty of bytes that give no channel.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [11:0] thr;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Bytes before any block start give nothing, escape codes included.
        send_byte(8'h05, 1'b0, 12'd3, 12'd3);
        send_byte(CODE_ABS32, 1'b0, 12'd2048, 12'd2048);

        // A four-channel block under the reset threshold and byte order:
        // zero, an 8-bit step of minus one, the most negative 16-bit step
        // and the largest absolute value, then a byte after the last channel.
        send_byte(8'h00, 1'b1, 12'd4, 12'd2048);
        send_byte(8'hff, 1'b0, 12'd0, 12'd0);
        send_byte(CODE_DIFF16, 1'b0, 12'd0, 12'd0);
        send_byte(8'h00, 1'b0, 12'd0, 12'd0);
        send_byte(8'h80, 1'b0, 12'd0, 12'd0);
        send_byte(CODE_ABS32, 1'b0, 12'd0, 12'd0);
        send_byte(8'hff, 1'b0, 12'd0, 12'd0);
        send_byte(8'hff, 1'b0, 12'd0, 12'd0);
        send_byte(8'hff, 1'b0, 12'd0, 12'd0);
        send_byte(8'h7f, 1'b0, 12'd0, 12'd0);
        send_byte(8'h7e, 1'b0, 12'd4095, 12'd4095);

        // A payload abandoned by a block start, a block clamped to no room,
        // and a block whose first byte is its only channel.
        send_byte(CODE_DIFF16, 1'b1, 12'd3, 12'd3);
        send_byte(8'h12, 1'b0, 12'd0, 12'd0);
        send_byte(8'h81, 1'b1, 12'd1, 12'd0);
        send_byte(8'h81, 1'b1, 12'd2, 12'd1);

        // With a zero threshold a single channel is lost entirely and two
        // channels shrink to one.
        settle();
        write_reg(REG_THRESHOLD, 12'd0);
        send_byte(8'h10, 1'b1, 12'd1, 12'd5);
        send_byte(8'h7e, 1'b1, 12'd2, 12'd2);

        // A count beyond the channel limit, and the byte order flipped in the
        // middle of an absolute value: the first two bytes go in most
        // significant first, the last two into the upper lanes.
        settle();
        write_reg(REG_BIG_ENDIAN, 12'd1);
        write_reg(REG_THRESHOLD, 12'd2048);
        send_byte(CODE_ABS32, 1'b1, 12'd4095, 12'd4095);
        send_byte(8'h12, 1'b0, 12'd0, 12'd0);
        send_byte(8'h34, 1'b0, 12'd0, 12'd0);
        settle();
        write_reg(REG_BIG_ENDIAN, 12'd0);
        send_byte(8'h56, 1'b0, 12'd0, 12'd0);
        send_byte(8'h78, 1'b0, 12'd0, 12'd0);
        send_byte(8'h01, 1'b0, 12'd0, 12'd0);

        // Random part: eight segments, two per pressure phase, each with its
        // own register setting.
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            int seg_start;
            settle();
            case (seg)
                0:       thr = 12'd2048;
                1:       thr = 12'd0;
                2:       thr = THRESHOLD_RESET;
                default: thr = ($urandom_range(3) == 0) ? 12'($urandom_range(2048))
                                                        : 12'($urandom_range(12));
            endcase
            write_reg(REG_THRESHOLD, thr);
            write_reg(REG_BIG_ENDIAN, {11'($urandom),
                                       (seg == 0) ? 1'b0 : (seg == 1) ? 1'b1
                                                                       : 1'($urandom)});
            case (seg / 2)
                0: begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1: begin
                    send_idle_pct = 79;
                    stall_pct    <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct    <= 79;
                end
                default: begin
                    send_idle_pct = 25;
                    stall_pct    <= 25;
                end
            endcase
            seg_start = bytes_sent;
            while (bytes_sent - seg_start < SEGMENT_BYTES) send_random_block();
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("differential_spectrum_decoder_core: match");
        end else begin
            $display("differential_spectrum_decoder_core: mismatch");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest correct run.
    initial begin
        #4000000;
        $display("differential_spectrum_decoder_core: mismatch");
        $finish;
    end

endmodule
